[rtl/lsra_pkg.sv]
// Package for the linear-scan register allocator: widths, codes, state enum.
// Used by the top level, controller, datapath and checker; depends on nothing.
`default_nettype none
package lsra_pkg;
    localparam int NUM_REGS_DEF = 12;
    localparam int ORDER_ENTRIES = 12;
    localparam int SLOT_SHIFT = 3;
    localparam logic [15:0] SPILL_MAX = 16'hFFFF;

    localparam logic [47:0] ORDER_RESET = 48'd280222829740560;
    localparam logic [3:0]  COUNT_RESET = 4'd12;
    localparam logic [15:0] CALLEE_RESET = 16'd61640;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [1:0] CFG_ORDER = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;
    localparam logic [1:0] CFG_CALLEE = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RETIRE,
        S_PLACE,
        S_INSERT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic retire_step;
        logic place;
        logic insert_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic retire_done;
        logic insert_done;
    } t_status;

    typedef struct packed {
        logic        op;
        logic [15:0] virtual_reg;
        logic [15:0] first_use;
        logic [15:0] last_use;
    } t_interval;

    typedef struct packed {
        logic [1:0]  index;
        logic [47:0] value;
    } t_cfg_write;

    typedef struct packed {
        logic [15:0] virtual_reg_out;
        logic        in_register;
        logic [3:0]  phys_reg;
        logic [18:0] slot_offset;
        logic        evicted_valid;
        logic [15:0] evicted_vreg;
        logic [18:0] evicted_offset;
        logic [15:0] slots_used;
        logic [15:0] callee_used;
    } t_result;
endpackage
`default_nettype wire

[rtl/lsra_if.sv]
// Valid/ready channel interface carrying a payload of any type.
// Depends on nothing.
`default_nettype none
interface lsra_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/linear_scan_register_allocator_top.sv]
// Top level of the linear-scan register allocator: config registers,
// controller and datapath. Depends on lsra_pkg, lsra_if, lsra_ctrl, lsra_dp.
`default_nettype none
// One interval is handled at a time. An allocate passes through the retire,
// place and insert states before its result is offered: the retirement pass
// walks the active intervals (up to NUM_REGS), and the insertion shifts entries
// (up to NUM_REGS - 1) to put the new one into the end-sorted active list; a
// clear goes straight to the result state. A stalled result holds the block
// and its input.
// Order and count writes take effect at the next clear; the callee mask at once.
module linear_scan_register_allocator_top
    import lsra_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lsra_if.sink      in_ch,
    lsra_if.source    out_ch,
    lsra_if.sink      cfg_ch
);
    logic [47:0] r_order;
    logic [3:0]  r_count;
    logic [15:0] r_callee;
    t_cmd        w_cmd;
    t_status     w_status;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
            r_count <= COUNT_RESET;
            r_callee <= CALLEE_RESET;
        end else if (cfg_ch.valid) begin
            unique case (cfg_ch.data.index)
                CFG_ORDER: r_order <= cfg_ch.data.value[47:0];
                CFG_COUNT: r_count <= cfg_ch.data.value[3:0];
                CFG_CALLEE: r_callee <= cfg_ch.data.value[15:0];
                default: ;
            endcase
        end
    end

    lsra_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid),
        .i_op(in_ch.data.op),
        .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .o_cmd(w_cmd),
        .i_status(w_status)
    );

    lsra_dp #(.NUM_REGS(NUM_REGS)) u_dp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd(w_cmd),
        .o_status(w_status),
        .i_vreg(in_ch.data.virtual_reg),
        .i_start(in_ch.data.first_use),
        .i_end(in_ch.data.last_use),
        .i_order(r_order),
        .i_count(r_count),
        .i_callee_mask(r_callee),
        .o_result(out_ch.data)
    );
endmodule
`default_nettype wire

[rtl/lsra_ctrl.sv]
// Controller state machine of the allocator.
// Depends on lsra_pkg.
`default_nettype none
module lsra_ctrl
    import lsra_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_op,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_cmd         o_cmd,
    input  wire t_status i_status
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_op == OP_CLEAR) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RETIRE;
                    end
                end
            end
            S_RETIRE: begin
                if (i_status.retire_done) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.retire_step = 1'b1;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state = S_INSERT;
            end
            S_INSERT: begin
                if (i_status.insert_done) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.insert_step = 1'b1;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/lsra_dp.sv]
// Datapath of the allocator: free queue, sorted active list, counters.
// Depends on lsra_pkg.
`default_nettype none
module lsra_dp
    import lsra_pkg::*;
#(
    parameter int NUM_REGS = NUM_REGS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    input  wire logic [15:0] i_vreg,
    input  wire logic [15:0] i_start,
    input  wire logic [15:0] i_end,
    input  wire logic [47:0] i_order,
    input  wire logic [3:0]  i_count,
    input  wire logic [15:0] i_callee_mask,
    output t_result          o_result
);
    localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CW = $clog2(NUM_REGS + 1);
    localparam logic [CW-1:0] FULL = CW'(NUM_REGS);
    localparam int CNT_RST = int'(COUNT_RESET);
    localparam int LIM_ORD = (CNT_RST > ORDER_ENTRIES) ? ORDER_ENTRIES : CNT_RST;
    localparam int LIM_RST = (LIM_ORD > NUM_REGS) ? NUM_REGS : LIM_ORD;

    logic [3:0]    r_fq [NUM_REGS];
    logic [CW-1:0] r_fcnt;
    logic [15:0]   r_av [NUM_REGS];
    logic [15:0]   r_ae [NUM_REGS];
    logic [3:0]    r_ar [NUM_REGS];
    logic [CW-1:0] r_acnt;
    logic [15:0]   r_spill;
    logic [15:0]   r_seen;
    logic [15:0]   r_vreg, r_start, r_end;
    logic [CW-1:0] r_ri;
    logic [CW-1:0] r_kept;
    logic [CW-1:0] r_pos;
    logic          r_ins;
    logic [3:0]    r_ins_reg;
    t_result       r_res;

    logic [3:0] lim;
    logic [IW-1:0] ri_ix, kept_ix, pos_ix, last_ix, fc_ix;
    logic [18:0] off_now;

    always_comb begin
        lim = (i_count > 4'(ORDER_ENTRIES)) ? 4'(ORDER_ENTRIES) : i_count;
        if (32'(lim) > NUM_REGS) lim = 4'(NUM_REGS);
        ri_ix = r_ri[IW-1:0];
        kept_ix = r_kept[IW-1:0];
        pos_ix = (r_pos == '0) ? '0 : IW'(r_pos - 1'b1);
        last_ix = (r_acnt == '0) ? '0 : IW'(r_acnt - 1'b1);
        fc_ix = r_fcnt[IW-1:0];
        off_now = {r_spill, 3'b000};
        o_status.retire_done = (r_ri >= r_acnt);
        o_status.insert_done = !r_ins || r_pos == '0 || r_ae[pos_ix] <= r_end;
        o_result = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_fq[i] <= (i < ORDER_ENTRIES) ? ORDER_RESET[4*(i%ORDER_ENTRIES) +: 4] : 4'd0;
            end
            r_fcnt <= CW'(LIM_RST);
            r_acnt <= '0;
            r_spill <= '0;
            r_seen <= '0;
            r_ins <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_vreg <= i_vreg;
                r_start <= i_start;
                r_end <= i_end;
                r_ri <= '0;
                r_kept <= '0;
                r_ins <= 1'b0;
                r_res <= '{virtual_reg_out: i_vreg, default: '0};
            end
            if (i_cmd.clear) begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    r_fq[i] <= (i < ORDER_ENTRIES) ? i_order[4*(i%ORDER_ENTRIES) +: 4] : 4'd0;
                end
                r_fcnt <= CW'(lim);
                r_acnt <= '0;
                r_spill <= '0;
                r_seen <= '0;
            end
            if (i_cmd.retire_step) begin
                if (r_ae[ri_ix] < r_start) begin
                    if (r_fcnt < FULL) begin
                        r_fq[fc_ix] <= r_ar[ri_ix];
                        r_fcnt <= r_fcnt + 1'b1;
                    end
                end else begin
                    r_av[kept_ix] <= r_av[ri_ix];
                    r_ae[kept_ix] <= r_ae[ri_ix];
                    r_ar[kept_ix] <= r_ar[ri_ix];
                    r_kept <= r_kept + 1'b1;
                end
                r_ri <= r_ri + 1'b1;
                if (r_ri + 1'b1 >= r_acnt) begin
                    r_acnt <= (r_ae[ri_ix] < r_start) ? r_kept : r_kept + 1'b1;
                end
            end
            if (i_cmd.place) begin
                if (r_fcnt != '0) begin
                    for (int i = 0; i < NUM_REGS - 1; i++) begin
                        r_fq[i] <= r_fq[i+1];
                    end
                    r_fcnt <= r_fcnt - 1'b1;
                    r_seen <= r_seen | (i_callee_mask & (16'd1 << r_fq[0]));
                    r_res.in_register <= 1'b1;
                    r_res.phys_reg <= r_fq[0];
                    r_ins <= (r_acnt < FULL);
                    r_ins_reg <= r_fq[0];
                    r_pos <= r_acnt;
                end else if (r_acnt != '0 && r_ae[last_ix] > r_end) begin
                    r_res.evicted_valid <= 1'b1;
                    r_res.evicted_vreg <= r_av[last_ix];
                    r_res.evicted_offset <= off_now;
                    if (r_spill != SPILL_MAX) r_spill <= r_spill + 1'b1;
                    r_res.in_register <= 1'b1;
                    r_res.phys_reg <= r_ar[last_ix];
                    r_ins <= 1'b1;
                    r_ins_reg <= r_ar[last_ix];
                    r_acnt <= r_acnt - 1'b1;
                    r_pos <= r_acnt - 1'b1;
                end else begin
                    r_res.slot_offset <= off_now;
                    if (r_spill != SPILL_MAX) r_spill <= r_spill + 1'b1;
                end
            end
            if (i_cmd.insert_step) begin
                r_av[r_pos[IW-1:0]] <= r_av[pos_ix];
                r_ae[r_pos[IW-1:0]] <= r_ae[pos_ix];
                r_ar[r_pos[IW-1:0]] <= r_ar[pos_ix];
                r_pos <= r_pos - 1'b1;
            end
            if (i_cmd.finish) begin
                if (r_ins) begin
                    r_av[r_pos[IW-1:0]] <= r_vreg;
                    r_ae[r_pos[IW-1:0]] <= r_end;
                    r_ar[r_pos[IW-1:0]] <= r_ins_reg;
                    r_acnt <= r_acnt + 1'b1;
                end
                r_res.slots_used <= r_spill;
                r_res.callee_used <= r_seen;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/lsra_checker.sv]
// Port-level checker for the allocator and its bind to the top level.
// Depends on lsra_pkg.
`default_nettype none
module lsra_checker
    import lsra_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_in_ready,
    input wire logic    i_out_valid,
    input wire logic    i_out_ready,
    input wire t_result i_res
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input taken while result waits");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res))
        else $error("result dropped or changed");
    a_spill_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_res.in_register |-> i_res.phys_reg == 4'd0)
        else $error("spilled interval with register");
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_res.evicted_valid |-> i_res.in_register &&
        i_res.slot_offset == 19'd0) else $error("bad eviction result");
endmodule

bind linear_scan_register_allocator_top lsra_checker u_chk (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_ready(in_ch.ready),
    .i_out_valid(out_ch.valid),
    .i_out_ready(out_ch.ready),
    .i_res(out_ch.data)
);
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for linear_scan_register_allocator_top.
// Predicts every allocation result and compares each output transfer field by field.
// Depends on lsra_pkg, lsra_if and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench
    import lsra_pkg::*;
();
    localparam int CYCLE_LIMIT = 3000000;
    localparam int NREG = 12;

    logic i_clk;
    logic i_rst_n;

    lsra_if #(.T(t_interval))  in_if ();
    lsra_if #(.T(t_result))    out_if ();
    lsra_if #(.T(t_cfg_write)) cfg_if ();

    linear_scan_register_allocator_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg_ch (cfg_if)
    );

    t_interval  interval_q[$];
    t_cfg_write cfg_q[$];
    t_result    alloc_expect_q[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    bit         send_pause;
    bit         hold_armed;
    int         hold_left;
    int         error_count;
    int         cycle_count;

    // Shadow of the allocator state and its registers.
    logic [47:0] cur_order;
    logic [3:0]  cur_count;
    logic [15:0] cur_callee_mask;
    logic [3:0]  idle_regs[NREG];
    int          free_len;
    logic [15:0] live_vreg[NREG];
    logic [15:0] live_end[NREG];
    logic [3:0]  live_reg[NREG];
    int          live_len;
    int          spill_slots;
    logic [15:0] callee_mark;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic reload_free();
        int n;
        n = (cur_count > 12) ? 12 : cur_count;
        if (n > NREG) n = NREG;
        for (int i = 0; i < n; i++) idle_regs[i] = cur_order[4*i +: 4];
        free_len = n;
        live_len = 0;
        spill_slots = 0;
        callee_mark = '0;
    endtask

    function automatic logic [18:0] next_slot();
        logic [18:0] off;
        off = 19'(spill_slots) << SLOT_SHIFT;
        if (spill_slots < 65535) spill_slots++;
        return off;
    endfunction

    task automatic add_live(logic [15:0] vreg, logic [15:0] e, logic [3:0] r);
        int pos;
        if (live_len >= NREG) return;
        pos = live_len;
        while (pos > 0 && live_end[pos-1] > e) pos--;
        for (int i = live_len; i > pos; i--) begin
            live_vreg[i] = live_vreg[i-1];
            live_end[i]  = live_end[i-1];
            live_reg[i]  = live_reg[i-1];
        end
        live_vreg[pos] = vreg;
        live_end[pos]  = e;
        live_reg[pos]  = r;
        live_len++;
    endtask

    task automatic allocate(t_interval it);
        t_result res;
        int kept;
        logic [3:0] r;
        res = '0;
        res.virtual_reg_out = it.virtual_reg;
        if (it.op == OP_CLEAR) begin
            reload_free();
        end else begin
            kept = 0;
            for (int i = 0; i < live_len; i++) begin
                if (live_end[i] < it.first_use) begin
                    if (free_len < NREG) idle_regs[free_len++] = live_reg[i];
                end else begin
                    live_vreg[kept] = live_vreg[i];
                    live_end[kept]  = live_end[i];
                    live_reg[kept]  = live_reg[i];
                    kept++;
                end
            end
            live_len = kept;
            if (free_len > 0) begin
                r = idle_regs[0];
                for (int i = 1; i < free_len; i++) idle_regs[i-1] = idle_regs[i];
                free_len--;
                callee_mark |= cur_callee_mask & (16'd1 << r);
                add_live(it.virtual_reg, it.last_use, r);
                res.in_register = 1'b1;
                res.phys_reg = r;
            end else if (live_len > 0 && live_end[live_len-1] > it.last_use) begin
                r = live_reg[live_len-1];
                res.evicted_valid  = 1'b1;
                res.evicted_vreg   = live_vreg[live_len-1];
                res.evicted_offset = next_slot();
                live_len--;
                add_live(it.virtual_reg, it.last_use, r);
                res.in_register = 1'b1;
                res.phys_reg = r;
            end else begin
                res.slot_offset = next_slot();
            end
            res.slots_used  = 16'(spill_slots);
            res.callee_used = callee_mark;
        end
        alloc_expect_q.insert(alloc_expect_q.size(), res);
    endtask

    // Interval driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data  <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                allocate(in_if.data);
                void'(interval_q.pop_front());
            end
            if (!in_if.valid || in_if.ready) begin
                if (interval_q.size() > 0 && !send_pause
                        && $urandom_range(99) >= send_idle_pct) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= interval_q[0];
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Register write driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_if.valid <= 1'b0;
            cfg_if.data  <= '0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.data.index)
                    CFG_ORDER:  cur_order = cfg_if.data.value;
                    CFG_COUNT:  cur_count = cfg_if.data.value[3:0];
                    CFG_CALLEE: cur_callee_mask = cfg_if.data.value[15:0];
                    default: ;
                endcase
                void'(cfg_q.pop_front());
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (cfg_q.size() > 0) begin
                    cfg_if.valid <= 1'b1;
                    cfg_if.data  <= cfg_q[0];
                end else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, armed once by the stimulus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_armed && in_if.valid) begin
            hold_left  <= 600;
            hold_armed <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", field, got, want);
        error_count++;
    endtask

    // Result monitor.
    always @(posedge i_clk) begin
        t_result w;
        t_result g;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                g = out_if.data;
                if (alloc_expect_q.size() == 0) begin
                    report("unexpected transfer", g.virtual_reg_out, 0);
                end else begin
                    w = alloc_expect_q.pop_front();
                    if (g.virtual_reg_out !== w.virtual_reg_out)
                        report("virtual_reg_out", g.virtual_reg_out, w.virtual_reg_out);
                    if (g.in_register !== w.in_register)
                        report("in_register", g.in_register, w.in_register);
                    if (g.phys_reg !== w.phys_reg)
                        report("phys_reg", g.phys_reg, w.phys_reg);
                    if (g.slot_offset !== w.slot_offset)
                        report("slot_offset", g.slot_offset, w.slot_offset);
                    if (g.evicted_valid !== w.evicted_valid)
                        report("evicted_valid", g.evicted_valid, w.evicted_valid);
                    if (g.evicted_vreg !== w.evicted_vreg)
                        report("evicted_vreg", g.evicted_vreg, w.evicted_vreg);
                    if (g.evicted_offset !== w.evicted_offset)
                        report("evicted_offset", g.evicted_offset, w.evicted_offset);
                    if (g.slots_used !== w.slots_used)
                        report("slots_used", g.slots_used, w.slots_used);
                    if (g.callee_used !== w.callee_used)
                        report("callee_used", g.callee_used, w.callee_used);
                end
            end
            out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push(logic op, logic [15:0] v, logic [15:0] s, logic [15:0] e);
        t_interval it;
        it.op = op;
        it.virtual_reg = v;
        it.first_use = s;
        it.last_use = e;
        interval_q.insert(interval_q.size(), it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        t_cfg_write w;
        w.index = idx;
        w.value = val;
        cfg_q.insert(cfg_q.size(), w);
    endtask

    // Register writes complete before any interval is offered.
    task automatic settle_cfg();
        while (cfg_q.size() > 0 || cfg_if.valid)
            @(posedge i_clk);
    endtask

    task automatic drain();
        while (interval_q.size() > 0 || alloc_expect_q.size() > 0 || cfg_q.size() > 0
                || cfg_if.valid)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_idling(int mode);
        send_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 72 : 0;
        recv_idle_pct = (mode == 0) ? 72 : (mode == 1) ? 7 : 0;
    endtask

    // One function body: mostly ordered intervals, with some noise.
    task automatic random_function(int n);
        int s;
        push(OP_ALLOC, 16'($urandom), 16'($urandom), 16'($urandom));
        push(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        s = $urandom_range(40);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 8) begin
                push(1'($urandom_range(1)), 16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                s += $urandom_range(3);
                push(OP_ALLOC, 16'($urandom), 16'(s), 16'(s + $urandom_range(50)));
            end
        end
    endtask

    initial begin
        logic [47:0] ord;
        cycle_count = 0;
        error_count = 0;
        send_pause = 1'b0;
        hold_armed = 1'b0;
        set_idling(0);
        cur_order = ORDER_RESET;
        cur_count = COUNT_RESET;
        cur_callee_mask = CALLEE_RESET;
        reload_free();
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, equal ends, start order violated, eviction.
        push(OP_ALLOC, 16'h0000, 16'h0000, 16'h0000);
        push(OP_ALLOC, 16'hFFFF, 16'h0000, 16'hFFFF);
        push(OP_ALLOC, 16'h1234, 16'h0001, 16'h0010);
        push(OP_ALLOC, 16'h1235, 16'h0002, 16'h0010);
        push(OP_ALLOC, 16'h0001, 16'hFFFF, 16'hFFFF);
        push(OP_ALLOC, 16'h0002, 16'h0005, 16'h0006);
        push(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 14; i++) push(OP_ALLOC, 16'(100 + i), 16'(i), 16'(200 - i));
        push(OP_ALLOC, 16'h0BAD, 16'd20, 16'd500);
        push(OP_ALLOC, 16'h0ACE, 16'd1000, 16'd1001);
        drain();

        // Duplicate register numbers, one register, every register callee-saved.
        write_reg(CFG_ORDER, 48'h777777777777);
        write_reg(CFG_COUNT, 48'd1);
        write_reg(CFG_CALLEE, 48'hFFFF);
        settle_cfg();
        push(OP_ALLOC, 16'd1, 16'd0, 16'd3);
        push(OP_CLEAR, 16'd2, 16'd0, 16'd0);
        push(OP_ALLOC, 16'd3, 16'd0, 16'd50);
        push(OP_ALLOC, 16'd4, 16'd1, 16'd10);
        push(OP_ALLOC, 16'd5, 16'd2, 16'd60);
        push(OP_ALLOC, 16'd6, 16'd70, 16'd80);
        drain();

        // Random phases, each with its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            set_idling(ph / 2);
            for (int i = 0; i < 12; i++) ord[4*i +: 4] = 4'($urandom_range(15));
            write_reg(CFG_ORDER, (ph == 5) ? 48'hFFFFFFFFFFFF : (ph == 4) ? 48'h0 : ord);
            write_reg(CFG_COUNT, (ph == 0) ? 48'd12 : (ph == 1) ? 48'd15 :
                                 (ph == 2) ? 48'd0 : 48'($urandom_range(15)));
            write_reg(CFG_CALLEE, (ph == 3) ? 48'h0 : 48'($urandom_range(65535)));
            settle_cfg();
            if (ph == 1) hold_armed = 1'b1;
            for (int f = 0; f < 6; f++) random_function($urandom_range(10, 60));
            if (ph == 3) begin
                while (interval_q.size() > 100) @(posedge i_clk);
                send_pause = 1'b1;
                while (alloc_expect_q.size() > 0 || in_if.valid) @(posedge i_clk);
                send_pause = 1'b0;
            end
            drain();
        end

        // Spill-heavy stretch with no registers.
        set_idling(2);
        write_reg(CFG_COUNT, 48'd0);
        settle_cfg();
        push(OP_CLEAR, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 120; i++)
            push(OP_ALLOC, 16'($urandom), 16'($urandom), 16'($urandom));
        drain();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
